### hdl/kmps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad matrix port scanner package
// Word types, access codes, register map and the keypad decode functions.
// ----------------------------------------------------------------------------
package kmps_pkg;

  // Key bitmap positions of the hook switch and the dial-A key.
  localparam int unsigned HOOK_BIT   = 20;
  localparam int unsigned DIAL_A_BIT = 30;

  localparam logic [31:0] HOOK_MASK = 32'd1 << HOOK_BIT;

  // Key bits packed into port C.
  localparam int unsigned PC_LOW_BASE = 12;
  localparam int unsigned PC_HIGH_0   = 16;
  localparam int unsigned PC_HIGH_1   = 17;
  localparam int unsigned PC_HIGH_2   = 18;

  // Key bit position for each row (first index) and column (second index).
  localparam logic [4:0] KEY_POS [4][4] = '{
    '{5'd0, 5'd1,  5'd2,  5'(DIAL_A_BIT)},
    '{5'd3, 5'd4,  5'd5,  5'd13},
    '{5'd6, 5'd7,  5'd8,  5'd14},
    '{5'd9, 5'd10, 5'd11, 5'd15}
  };

  // Access codes.
  localparam logic [2:0] CMD_WR_B    = 3'd0;
  localparam logic [2:0] CMD_WR_C    = 3'd1;
  localparam logic [2:0] CMD_WR_CTRL = 3'd2;
  localparam logic [2:0] CMD_RD_A    = 3'd3;
  localparam logic [2:0] CMD_RD_B    = 3'd4;
  localparam logic [2:0] CMD_RD_C    = 3'd5;
  localparam logic [2:0] CMD_HOOK    = 3'd6;
  localparam logic [2:0] CMD_CONSUME = 3'd7;

  // Register indexes (byte address bits 3:2).
  localparam logic [1:0] REG_DEBOUNCE_SPAN      = 2'd0;
  localparam logic [1:0] REG_MIN_SCAN_READS     = 2'd1;
  localparam logic [1:0] REG_MIN_STROBE_CHANGES = 2'd2;

  localparam int unsigned CFG_ADDR_W = 4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  wr_data;
    logic [31:0] key_bits;
    logic [63:0] time_stamp;
  } kmps_in_t;

  typedef struct packed {
    logic [7:0]  rd_data;
    logic [31:0] keys_debounced;
    logic        scan_event;
  } kmps_out_t;

  // Active-low row lines for a port A read. The high nibble of the strobe
  // is searched first; with no column strobed all columns are merged.
  function automatic logic [3:0] port_a_rows(input logic [7:0] strobe,
                                             input logic [31:0] keys);
    logic [3:0] hi;
    logic [3:0] lo;
    logic [3:0] sel;
    logic [3:0] col_mask;
    logic [3:0] rows;
    hi  = ~strobe[7:4];
    lo  = ~strobe[3:0];
    sel = (hi != 4'd0) ? hi : lo;
    if (sel == 4'd0) begin
      col_mask = 4'hf;
    end else begin
      col_mask = sel & (~sel + 4'd1);
    end
    rows = 4'hf;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (col_mask[c] && keys[KEY_POS[r][c]]) begin
          rows[r] = 1'b0;
        end
      end
    end
    return rows;
  endfunction

  // Fixed keys of port C, active low.
  function automatic logic [7:0] port_c_value(input logic [31:0] keys);
    logic [3:0] low;
    logic [3:0] high;
    low  = ~keys[PC_LOW_BASE +: 4];
    high = ~{keys[DIAL_A_BIT], keys[PC_HIGH_2], keys[PC_HIGH_1], keys[PC_HIGH_0]};
    return {high, low};
  endfunction

endpackage

### hdl/kmps_hook.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hook switch debounce
// Tracks the raw hook bit and the time of its last change, and accepts the
// raw value once it has held for the configured span.
// ----------------------------------------------------------------------------
module kmps_hook (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        hook_en,
  input  logic [31:0] key_bits,
  input  logic [63:0] time_stamp,
  input  logic [30:0] debounce_span,
  output logic [31:0] keys_debounced
);
  import kmps_pkg::*;

  logic        hook_raw_r;
  logic        hook_stable_r;
  logic [63:0] change_time_r;
  logic        raw;
  logic        changed;
  logic        settled;
  logic        stable_nxt;
  logic [64:0] deadline;

  assign raw     = key_bits[HOOK_BIT];
  assign changed = raw != hook_raw_r;

  // A fresh change restarts the span, so only a zero span can pass then.
  assign deadline = {1'b0, change_time_r} + {34'd0, debounce_span};
  assign settled  = (debounce_span == 31'd0) ||
                    (!changed && ({1'b0, time_stamp} >= deadline));

  assign stable_nxt     = settled ? raw : hook_stable_r;
  assign keys_debounced = (key_bits & ~HOOK_MASK) | (stable_nxt ? HOOK_MASK : 32'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hook_raw_r    <= 1'b0;
      hook_stable_r <= 1'b0;
      change_time_r <= 64'd0;
    end else if (hook_en) begin
      hook_raw_r    <= raw;
      hook_stable_r <= stable_nxt;
      if (changed) begin
        change_time_r <= time_stamp;
      end
    end
  end

endmodule

### hdl/keypad_matrix_port_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad matrix port scanner
// Port block of a keypad: column strobe latch, row scan, fixed-key port,
// hook debounce and a one-shot scan event.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one bus access per word (in_valid, in_stall,
//   in_data). Every access yields exactly one result word on the output
//   channel (out_valid, out_stall, out_data), in access order.
//   The block takes one access per cycle while in_stall is low. A result
//   waits in the output or skid register until taken. The decode, the
//   scan counters and the hook compare are all done in the accept cycle;
//   the 64-bit debounce add and compare sets the clock limit.
//   An output register backed by one skid register lets an access be taken
//   while a result waits; in_stall rises only once both hold a word, so a
//   stalled receiver holds the input side off after two buffered results.
//   Registers are written through the APB-style port at byte addresses 0, 4
//   and 8 and read back the same way; writes belong in idle periods.
//   Synchronous reset restores the strobe latch to all ones, clears counters,
//   the event and the hook state, loads the register defaults and empties
//   both output registers.
// ----------------------------------------------------------------------------
module keypad_matrix_port_scanner (
  input  logic                                clk,
  input  logic                                rst_n,
  // Access channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  kmps_pkg::kmps_in_t                  in_data,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output kmps_pkg::kmps_out_t                 out_data,
  // Register port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [kmps_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import kmps_pkg::*;

  // Registers.
  logic [30:0] debounce_span_r;
  logic [15:0] min_scan_reads_r;
  logic [15:0] min_strobe_changes_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  // Scan state.
  logic [7:0]  strobe_latch_r, strobe_latch_nxt;
  logic [7:0]  prev_strobe_r, prev_strobe_nxt;
  logic [15:0] read_count_r, read_count_nxt;
  logic [15:0] change_count_r, change_count_nxt;
  logic        event_pending_r, event_pending_nxt;
  logic        event_fired_r, event_fired_nxt;

  // Handshake and output buffering.
  logic        in_acc;
  logic        out_take;
  logic        out_valid_r;
  logic        skid_valid_r;
  kmps_out_t   out_data_r;
  kmps_out_t   skid_data_r;
  kmps_out_t   result;

  logic        hook_en;
  logic [31:0] keys_hook;
  logic [15:0] need_reads;
  logic [15:0] need_changes;
  logic [15:0] reads_inc;
  logic [15:0] changes_inc;
  logic        strobe_moved;
  logic        fire;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    unique case (cfg_idx)
      REG_DEBOUNCE_SPAN:      prdata = {1'b0, debounce_span_r};
      REG_MIN_SCAN_READS:     prdata = {16'd0, min_scan_reads_r};
      REG_MIN_STROBE_CHANGES: prdata = {16'd0, min_strobe_changes_r};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_span_r      <= 31'd0;
      min_scan_reads_r     <= 16'd1;
      min_strobe_changes_r <= 16'd1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DEBOUNCE_SPAN:      debounce_span_r      <= pwdata[30:0];
        REG_MIN_SCAN_READS:     min_scan_reads_r     <= pwdata[15:0];
        REG_MIN_STROBE_CHANGES: min_strobe_changes_r <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // The input side stalls only when both result registers are occupied.
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_take  = out_valid_r && !out_stall;

  assign hook_en = in_acc && (in_data.cmd == CMD_HOOK);

  kmps_hook u_hook (
    .clk            (clk),
    .rst_n          (rst_n),
    .hook_en        (hook_en),
    .key_bits       (in_data.key_bits),
    .time_stamp     (in_data.time_stamp),
    .debounce_span  (debounce_span_r),
    .keys_debounced (keys_hook)
  );

  // A zero threshold behaves as one. Both counters stop at all ones.
  assign need_reads   = (min_scan_reads_r == 16'd0) ? 16'd1 : min_scan_reads_r;
  assign need_changes = (min_strobe_changes_r == 16'd0) ? 16'd1 : min_strobe_changes_r;
  assign reads_inc    = (read_count_r == 16'hffff) ? read_count_r : read_count_r + 16'd1;
  assign strobe_moved = strobe_latch_r != prev_strobe_r;
  assign changes_inc  = (strobe_moved && (change_count_r != 16'hffff)) ?
                        change_count_r + 16'd1 : change_count_r;
  assign fire = !event_fired_r && (reads_inc >= need_reads) &&
                (changes_inc >= need_changes);

  always_comb begin
    strobe_latch_nxt  = strobe_latch_r;
    prev_strobe_nxt   = prev_strobe_r;
    read_count_nxt    = read_count_r;
    change_count_nxt  = change_count_r;
    event_pending_nxt = event_pending_r;
    event_fired_nxt   = event_fired_r;
    result            = '0;
    unique case (in_data.cmd) inside
      CMD_WR_B: begin
        strobe_latch_nxt = in_data.wr_data;
      end
      CMD_RD_A: begin
        read_count_nxt   = reads_inc;
        change_count_nxt = changes_inc;
        prev_strobe_nxt  = strobe_latch_r;
        if (fire) begin
          event_pending_nxt = 1'b1;
          event_fired_nxt   = 1'b1;
        end
        result.rd_data = {4'd0, port_a_rows(strobe_latch_r, in_data.key_bits)};
      end
      CMD_RD_B: begin
        result.rd_data = strobe_latch_r;
      end
      CMD_RD_C: begin
        result.rd_data = port_c_value(in_data.key_bits);
      end
      CMD_HOOK: begin
        result.keys_debounced = keys_hook;
      end
      CMD_CONSUME: begin
        result.scan_event = event_pending_r;
        event_pending_nxt = 1'b0;
      end
      // Port C and control writes have no visible effect.
      CMD_WR_C, CMD_WR_CTRL: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_latch_r  <= 8'hff;
      prev_strobe_r   <= 8'hff;
      read_count_r    <= 16'd0;
      change_count_r  <= 16'd0;
      event_pending_r <= 1'b0;
      event_fired_r   <= 1'b0;
    end else if (in_acc) begin
      strobe_latch_r  <= strobe_latch_nxt;
      prev_strobe_r   <= prev_strobe_nxt;
      read_count_r    <= read_count_nxt;
      change_count_r  <= change_count_nxt;
      event_pending_r <= event_pending_nxt;
      event_fired_r   <= event_fired_nxt;
    end
  end

  // Output register with skid. The skid word always refills the output
  // register first, which keeps results in order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take || !out_valid_r) begin
      out_valid_r  <= skid_valid_r || in_acc;
      skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid_r) begin
      out_data_r <= skid_valid_r ? skid_data_r : result;
    end else if (in_acc) begin
      skid_data_r <= result;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a word while the output register is empty");

  a_event_once: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(event_pending_r) |-> !$past(event_fired_r))
    else $error("scan event raised a second time");

  a_reads_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    (read_count_r == 16'hffff) |=> (read_count_r == 16'hffff))
    else $error("read counter wrapped past its maximum");

  a_stalled_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && !skid_valid_r && in_acc) |=> skid_valid_r)
    else $error("result accepted under stall was not kept in the skid register");
`endif

endmodule
